/* hw/rtl/delta_varint_triple_decoder_unit_defines.svh */
// assertion macros shared by the decoder rtl
`ifndef DELTA_VARINT_TRIPLE_DECODER_UNIT_DEFINES_SVH
`define DELTA_VARINT_TRIPLE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// plain property checked every cycle out of reset
`define DVTD_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dvtd check failed");
// antecedent this cycle, consequent next cycle
`define DVTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvtd check failed");
`else
`define DVTD_ASSERT(lbl, clk, rst_n, expr)
`define DVTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/dvtd_pkg.sv */
`timescale 1ns / 1ps

package dvtd_pkg;

    localparam int NUM_COLS         = 3;
    localparam int TERM_W           = 64;
    localparam int VARINT_MAX_BYTES = 10;
    localparam int CMD_DEPTH        = 2;
    localparam int CMD_AW           = $clog2(CMD_DEPTH);
    localparam int CMD_CW           = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH        = 2;
    localparam int RES_AW           = $clog2(RES_DEPTH);
    localparam int RES_CW           = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] SLOT_NONE = 2'd3;

    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_TRIPLES = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_LONG  = 2'd2,
        ST_TRAIL = 2'd3
    } t_status;

    typedef logic [NUM_COLS-1:0][1:0]        t_slot_map;
    typedef logic [NUM_COLS-1:0][TERM_W-1:0] t_terms;

    // work item from the front to the back
    typedef struct packed {
        logic              is_add;
        logic [1:0]        col;
        logic [TERM_W-1:0] value;
        logic              emit;
        logic              valid;
        t_status           status;
        logic              done;
    } t_cmd;

    typedef struct packed {
        t_terms  terms;
        logic    valid;
        t_status status;
        logic    done;
    } t_res;

endpackage

/* hw/rtl/dvtd_front.sv */
`timescale 1ns / 1ps

`include "delta_varint_triple_decoder_unit_defines.svh"

module dvtd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output logic                 o_cmd_push,
    output dvtd_pkg::t_cmd       o_cmd
);

    dvtd_pkg::t_phase                  r_phase, n_phase;
    logic [dvtd_pkg::TERM_W-1:0]       r_acc, n_acc;
    logic [3:0]                        r_vbytes, n_vbytes;
    logic [1:0]                        r_col, n_col;
    logic [dvtd_pkg::TERM_W-1:0]       r_left, n_left;
    dvtd_pkg::t_status                 r_err, n_err;

    logic [5:0]                        w_shamt;
    logic [dvtd_pkg::TERM_W-1:0]       w_acc;
    logic [3:0]                        w_vb_inc;
    logic [dvtd_pkg::TERM_W-1:0]       w_left_dec;

    // 7 * byte count, at most 63 while a varint is open
    assign w_shamt    = ({2'b0, r_vbytes} << 3) - {2'b0, r_vbytes};
    assign w_acc      = r_acc | ({{(dvtd_pkg::TERM_W-7){1'b0}}, i_byte[6:0]} << w_shamt);
    assign w_vb_inc   = r_vbytes + 4'd1;
    assign w_left_dec = r_left - {{(dvtd_pkg::TERM_W-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dvtd_pkg::PH_COUNT;
            r_acc    <= '0;
            r_vbytes <= '0;
            r_col    <= '0;
            r_left   <= '0;
            r_err    <= dvtd_pkg::ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_vbytes <= n_vbytes;
            r_col    <= n_col;
            r_left   <= n_left;
            r_err    <= n_err;
        end
    end

    always_comb begin
        logic do_clear;
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_vbytes   = r_vbytes;
        n_col      = r_col;
        n_left     = r_left;
        n_err      = r_err;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        do_clear   = 1'b0;

        if (i_accept) begin
            case (r_phase)
                dvtd_pkg::PH_COUNT, dvtd_pkg::PH_TRIPLES: begin
                    if (r_phase == dvtd_pkg::PH_TRIPLES && r_left == '0 && r_vbytes == '0) begin
                        // byte after the last expected triple
                        o_cmd_push   = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = dvtd_pkg::ST_TRAIL;
                        o_cmd.done   = i_end;
                        do_clear     = i_end;
                        n_phase      = dvtd_pkg::PH_DISCARD;
                        n_err        = dvtd_pkg::ST_TRAIL;
                    end else if (i_byte[7]) begin
                        n_acc    = w_acc;
                        n_vbytes = w_vb_inc;
                        if (w_vb_inc >= 4'(dvtd_pkg::VARINT_MAX_BYTES)) begin
                            o_cmd_push   = 1'b1;
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = dvtd_pkg::ST_LONG;
                            o_cmd.done   = i_end;
                            do_clear     = i_end;
                            n_phase      = dvtd_pkg::PH_DISCARD;
                            n_err        = dvtd_pkg::ST_LONG;
                        end else if (i_end) begin
                            o_cmd_push   = 1'b1;
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = dvtd_pkg::ST_TRUNC;
                            o_cmd.done   = 1'b1;
                            do_clear     = 1'b1;
                        end
                    end else begin
                        n_acc    = '0;
                        n_vbytes = '0;
                        if (r_phase == dvtd_pkg::PH_COUNT) begin
                            n_left  = w_acc;
                            n_phase = dvtd_pkg::PH_TRIPLES;
                            n_col   = '0;
                            if (i_end) begin
                                o_cmd_push   = 1'b1;
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = (w_acc != '0) ? dvtd_pkg::ST_TRUNC
                                                             : dvtd_pkg::ST_OK;
                                o_cmd.done   = 1'b1;
                                do_clear     = 1'b1;
                            end
                        end else begin
                            // delta for the current column
                            o_cmd_push   = 1'b1;
                            o_cmd.is_add = 1'b1;
                            o_cmd.col    = r_col;
                            o_cmd.value  = w_acc;
                            if (r_col != 2'(dvtd_pkg::NUM_COLS - 1)) begin
                                n_col = r_col + 2'd1;
                                if (i_end) begin
                                    o_cmd.emit   = 1'b1;
                                    o_cmd.status = dvtd_pkg::ST_TRUNC;
                                    o_cmd.done   = 1'b1;
                                    do_clear     = 1'b1;
                                end
                            end else begin
                                n_col        = '0;
                                n_left       = w_left_dec;
                                o_cmd.emit   = 1'b1;
                                o_cmd.valid  = 1'b1;
                                o_cmd.status = (i_end && w_left_dec != '0) ? dvtd_pkg::ST_TRUNC
                                                                           : dvtd_pkg::ST_OK;
                                o_cmd.done   = i_end;
                                do_clear     = i_end;
                            end
                        end
                    end
                end
                default: begin
                    // discarding until the end marker
                    if (i_end) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = r_err;
                        o_cmd.done   = 1'b1;
                        do_clear     = 1'b1;
                    end
                end
            endcase
        end

        if (do_clear) begin
            n_phase  = dvtd_pkg::PH_COUNT;
            n_acc    = '0;
            n_vbytes = '0;
            n_col    = '0;
            n_left   = '0;
            n_err    = dvtd_pkg::ST_OK;
        end
    end

    // the byte count stops at the limit once an over-long varint sends the front to discard
    `DVTD_ASSERT(a_vbytes_range, i_clk, i_rst_n, r_vbytes <= 4'(dvtd_pkg::VARINT_MAX_BYTES))
    `DVTD_ASSERT(a_discard_quiet, i_clk, i_rst_n, !(r_phase == dvtd_pkg::PH_DISCARD && o_cmd_push) || i_end)

endmodule

/* hw/rtl/dvtd_cmd_queue.sv */
`timescale 1ns / 1ps

`include "delta_varint_triple_decoder_unit_defines.svh"

module dvtd_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dvtd_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output dvtd_pkg::t_cmd  o_data
);

    dvtd_pkg::t_cmd                   r_mem [dvtd_pkg::CMD_DEPTH];
    logic [dvtd_pkg::CMD_AW-1:0]      r_wptr, n_wptr;
    logic [dvtd_pkg::CMD_AW-1:0]      r_rptr, n_rptr;
    logic [dvtd_pkg::CMD_CW-1:0]      r_count, n_count;
    logic                             w_wr, w_rd;

    assign o_full  = (r_count == dvtd_pkg::CMD_CW'(dvtd_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == dvtd_pkg::CMD_AW'(dvtd_pkg::CMD_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == dvtd_pkg::CMD_AW'(dvtd_pkg::CMD_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `DVTD_ASSERT(a_cmd_no_overflow, i_clk, i_rst_n, !(i_push && o_full))

endmodule

/* hw/rtl/dvtd_res_queue.sv */
`timescale 1ns / 1ps

module dvtd_res_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dvtd_pkg::t_res  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output dvtd_pkg::t_res  o_data
);

    dvtd_pkg::t_res                   r_mem [dvtd_pkg::RES_DEPTH];
    logic [dvtd_pkg::RES_AW-1:0]      r_wptr, n_wptr;
    logic [dvtd_pkg::RES_AW-1:0]      r_rptr, n_rptr;
    logic [dvtd_pkg::RES_CW-1:0]      r_count, n_count;
    logic                             w_wr, w_rd;

    assign o_full  = (r_count == dvtd_pkg::RES_CW'(dvtd_pkg::RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == dvtd_pkg::RES_AW'(dvtd_pkg::RES_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == dvtd_pkg::RES_AW'(dvtd_pkg::RES_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/dvtd_back.sv */
`timescale 1ns / 1ps

`include "delta_varint_triple_decoder_unit_defines.svh"

module dvtd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dvtd_pkg::t_slot_map  i_slot_map,
    input  logic                 i_cmd_empty,
    input  dvtd_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    input  logic                 i_res_full,
    output logic                 o_res_push,
    output dvtd_pkg::t_res       o_res
);

    dvtd_pkg::t_terms               r_run, n_run;
    dvtd_pkg::t_terms               r_slotv, n_slotv;
    dvtd_pkg::t_terms               w_run_upd, w_slot_upd;
    logic [dvtd_pkg::TERM_W-1:0]    w_sum;
    logic [1:0]                     w_slot;

    assign o_cmd_pop  = !i_cmd_empty && !i_res_full;
    assign o_res_push = o_cmd_pop && i_cmd.emit;
    assign w_sum      = r_run[i_cmd.col] + i_cmd.value;
    assign w_slot     = i_slot_map[i_cmd.col];

    always_comb begin
        w_run_upd  = r_run;
        w_slot_upd = r_slotv;
        if (i_cmd.is_add) begin
            w_run_upd[i_cmd.col] = w_sum;
            // slot code three drops the column
            if (w_slot != dvtd_pkg::SLOT_NONE) begin
                w_slot_upd[w_slot] = w_sum;
            end
        end
        n_run   = r_run;
        n_slotv = r_slotv;
        if (o_cmd_pop) begin
            n_run   = i_cmd.done ? '0 : w_run_upd;
            n_slotv = i_cmd.done ? '0 : w_slot_upd;
        end
        o_res.terms  = i_cmd.valid ? w_slot_upd : '0;
        o_res.valid  = i_cmd.valid;
        o_res.status = i_cmd.status;
        o_res.done   = i_cmd.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_slotv <= '0;
        end else begin
            r_run   <= n_run;
            r_slotv <= n_slotv;
        end
    end

    `DVTD_ASSERT(a_valid_from_add, i_clk, i_rst_n, !(o_res_push && o_res.valid) || i_cmd.is_add)
    `DVTD_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, o_cmd_pop && i_cmd.done, r_run == '0 && r_slotv == '0)

endmodule

/* hw/rtl/delta_varint_triple_decoder_unit.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// input     in         push / full               i_in_byte, i_end_of_data
// result    out        empty / pop               o_term_*, o_triple_valid, o_status,
//                                                o_stream_done
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while full stays low; a byte that closes a triple or raises an error shows on the
// result ports after it passes through the command queue, then the result queue
// throughput is set by the front varint shift-or and the back 64-bit column add
// synchronous active-low reset: returns to the count header, zeroes running values
// and slot values, restores the slot map to columns 0,1,2 -> slots 0,1,2
// both queues hold two entries; once both fill, a stall on the result side holds off the input through full

module delta_varint_triple_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_end_of_data,
    // result output
    output logic                          empty,
    input  logic                          pop,
    output logic [dvtd_pkg::TERM_W-1:0]   o_term_first,
    output logic [dvtd_pkg::TERM_W-1:0]   o_term_second,
    output logic [dvtd_pkg::TERM_W-1:0]   o_term_third,
    output logic                          o_triple_valid,
    output logic [1:0]                    o_status,
    output logic                          o_stream_done,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [1:0]                    i_cfg_data
);

    dvtd_pkg::t_slot_map  r_slot_map;
    dvtd_pkg::t_cmd       w_front_cmd;
    dvtd_pkg::t_cmd       w_back_cmd;
    dvtd_pkg::t_res       w_back_res;
    dvtd_pkg::t_res       w_out_res;
    logic                 w_accept;
    logic                 w_cmd_push;
    logic                 w_cmd_pop;
    logic                 w_cmd_empty;
    logic                 w_res_push;
    logic                 w_res_full;

    // slot registers are always writable; the user must change them only while the block is idle (not enforced here)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_map[0] <= 2'd0;
            r_slot_map[1] <= 2'd1;
            r_slot_map[2] <= 2'd2;
        end else if (i_cfg_valid && o_cfg_ready
                     && i_cfg_index < 2'(dvtd_pkg::NUM_COLS)) begin
            // writes to unlisted indexes are dropped
            r_slot_map[i_cfg_index] <= i_cfg_data;
        end
    end

    // byte transfer: full only reflects the command queue
    assign w_accept = push && !full;

    // front: varint assembly, header count, triple bookkeeping, error detection
    dvtd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte     (i_in_byte),
        .i_end      (i_end_of_data),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_front_cmd)
    );

    // decouples the byte side from the column adder
    dvtd_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_data  (w_back_cmd)
    );

    // back: running sums per column and slot placement
    dvtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_slot_map  (r_slot_map),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_back_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_back_res)
    );

    // finished results wait here until popped
    dvtd_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_back_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out_res)
    );

    assign o_term_first   = w_out_res.terms[0];
    assign o_term_second  = w_out_res.terms[1];
    assign o_term_third   = w_out_res.terms[2];
    assign o_triple_valid = w_out_res.valid;
    assign o_status       = w_out_res.status;
    assign o_stream_done  = w_out_res.done;

endmodule
